// ===== hdl/pmst_pkg.sv =====
// Shared types, constants and helpers of the persistent mismatch streak table.
package pmst_pkg;

  // Table geometry
  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);

  // Field widths
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned XY_W       = 7;
  localparam int unsigned ENTRY_W    = 16;
  localparam int unsigned STREAK_W   = 16;
  localparam int unsigned KEY_W      = 1 + 2 * XY_W;
  localparam int unsigned SLOT_OUT_W = 8;

  localparam logic [STREAK_W-1:0] STREAK_MAX = '1;
  localparam logic [STREAK_W-1:0] STREAK_ONE = STREAK_W'(1);
  localparam logic [STREAK_W-1:0] THR_RESET  = STREAK_W'(30);

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_THR    = 1'b0;  // register index, paddr[2]

  // One slot as stored in the table memory
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [STREAK_W-1:0] streak;
    logic [FRAME_W-1:0]  last_frame;
    logic [ENTRY_W-1:0]  expected;
    logic [ENTRY_W-1:0]  actual;
    logic                reported;
  } slot_entry_t;

  localparam int unsigned SLOT_W = $bits(slot_entry_t);

  // Memory access request from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } mem_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ctrl_state_e;

  // Slot index as reported: low bits, zero extended when the table is small
  function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_OUT_W-1:0];
  endfunction

endpackage

// ===== hdl/pmst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pmst_cfg.sv =====
// APB register file holding the streak threshold.
module pmst_cfg import pmst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [STREAK_W-1:0]   thr_o
);

  logic [STREAK_W-1:0] thr_q, thr_d;
  logic                wr_en;

  // write decode: byte address bits ignored
  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_THR);

  always_comb begin
    thr_d = thr_q;
    if (wr_en) begin
      thr_d = pwdata[STREAK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else begin
      thr_q <= thr_d;
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_THR) ? APB_DATA_W'(thr_q) : '0;
  assign pready = 1'b1;
  assign thr_o  = thr_q;

endmodule

// ===== hdl/pmst_ctrl.sv =====
// Sequencer: scans the slot memory, updates or allocates a slot, emits the result.
module pmst_ctrl import pmst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [FRAME_W-1:0]    frame_number_i,
  input  logic                  layer_id_i,
  input  logic [XY_W-1:0]       map_x_i,
  input  logic [XY_W-1:0]       map_y_i,
  input  logic [ENTRY_W-1:0]    expected_entry_i,
  input  logic [ENTRY_W-1:0]    actual_entry_i,
  input  logic [STREAK_W-1:0]   thr_i,
  output mem_req_t              mem_req_o,
  output slot_entry_t           mem_wdata_o,
  input  slot_entry_t           mem_rdata_i,
  output logic                  done_o,
  output logic                  persistent_report_o,
  output logic [STREAK_W-1:0]   streak_length_o,
  output logic [SLOT_OUT_W-1:0] slot_number_o,
  output logic                  event_dropped_o
);

  ctrl_state_e state_q, state_d;

  // scan bookkeeping
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;

  // captured beat
  logic [FRAME_W-1:0] frame_q;
  logic [KEY_W-1:0]   key_q;
  logic [ENTRY_W-1:0] exp_q, act_q;

  // result registers
  logic                  done_q, done_d;
  logic                  rep_q, rep_d;
  logic [STREAK_W-1:0]   streak_q, streak_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic                  drop_q, drop_d;

  logic                accept;
  logic                hit, scan_end;
  logic                consec;
  logic [STREAK_W-1:0] new_streak;
  logic                old_rep, report;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // hit update arithmetic on the slot just read
  assign hit      = chk_vld_q && (mem_rdata_i.key == key_q);
  assign scan_end = (rd_idx_q == fill_q);
  assign consec   = (mem_rdata_i.last_frame == (frame_q - FRAME_W'(1)));

  always_comb begin
    if (!consec) begin
      new_streak = STREAK_ONE;
    end else if (mem_rdata_i.streak == STREAK_MAX) begin
      new_streak = STREAK_MAX;
    end else begin
      new_streak = mem_rdata_i.streak + STREAK_ONE;
    end
  end

  assign old_rep = consec && mem_rdata_i.reported;
  assign report  = (new_streak == thr_i) && !old_rep;

  // next state, memory access and result
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    rd_idx_d  = rd_idx_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    done_d    = 1'b0;
    rep_d     = rep_q;
    streak_d  = streak_q;
    slot_d    = slot_q;
    drop_d    = drop_q;

    mem_req_o.rd_en   = 1'b0;
    mem_req_o.rd_addr = rd_idx_q[IDX_W-1:0];
    mem_req_o.wr_en   = 1'b0;
    mem_req_o.wr_addr = chk_idx_q;

    mem_wdata_o.key        = key_q;
    mem_wdata_o.streak     = new_streak;
    mem_wdata_o.last_frame = frame_q;
    mem_wdata_o.expected   = exp_q;
    mem_wdata_o.actual     = act_q;
    mem_wdata_o.reported   = old_rep || report;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d  = ST_SCAN;
          rd_idx_d = '0;
        end
      end
      ST_SCAN: begin
        // issue the next read while checking the previous one
        if (rd_idx_q < fill_q) begin
          mem_req_o.rd_en = 1'b1;
          rd_idx_d        = rd_idx_q + CNT_W'(1);
          chk_vld_d       = 1'b1;
          chk_idx_d       = rd_idx_q[IDX_W-1:0];
        end
        priority if (hit) begin
          mem_req_o.wr_en = 1'b1;
          state_d         = ST_IDLE;
          chk_vld_d       = 1'b0;
          done_d          = 1'b1;
          rep_d           = report;
          streak_d        = new_streak;
          slot_d          = slot_out(chk_idx_q);
          drop_d          = 1'b0;
        end else if (scan_end) begin
          // key absent: take the next free slot, or drop
          state_d   = ST_IDLE;
          chk_vld_d = 1'b0;
          done_d    = 1'b1;
          rep_d     = 1'b0;
          if (fill_q < CNT_W'(SLOT_COUNT)) begin
            mem_req_o.wr_en        = 1'b1;
            mem_req_o.wr_addr      = fill_q[IDX_W-1:0];
            mem_wdata_o.streak     = STREAK_ONE;
            mem_wdata_o.reported   = 1'b0;
            fill_d                 = fill_q + CNT_W'(1);
            streak_d               = STREAK_ONE;
            slot_d                 = slot_out(fill_q[IDX_W-1:0]);
            drop_d                 = 1'b0;
          end else begin
            streak_d = '0;
            slot_d   = '0;
            drop_d   = 1'b1;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_idx_q  <= rd_idx_d;
      chk_vld_q <= chk_vld_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    rep_q     <= rep_d;
    streak_q  <= streak_d;
    slot_q    <= slot_d;
    drop_q    <= drop_d;
    if (accept) begin
      frame_q <= frame_number_i;
      key_q   <= {layer_id_i, map_y_i, map_x_i};
      exp_q   <= expected_entry_i;
      act_q   <= actual_entry_i;
    end
  end

  assign done_o              = done_q;
  assign persistent_report_o = rep_q;
  assign streak_length_o     = streak_q;
  assign slot_number_o       = slot_q;
  assign event_dropped_o     = drop_q;

`ifndef SYNTHESIS
  // a result only follows a scan cycle
  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == ST_SCAN)
    else $error("result without a preceding scan");

  // the fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(SLOT_COUNT))
    else $error("fill count overflow");

  // reads never run past the allocated slots
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= fill_q)
    else $error("scan index past fill count");

  // every write back closes the item with a result
  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |=> done_q && !drop_q)
    else $error("slot written without a result");

  // a drop only happens on a full table and reports no streak
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && drop_q |-> fill_q == CNT_W'(SLOT_COUNT) && streak_q == '0 && !rep_q)
    else $error("drop with free slots left");
`endif

endmodule

// ===== hdl/persistent_mismatch_streak_table_unit.sv =====
// Top level of the persistent mismatch streak table.
// An event is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done_o high and cannot be held off.
// An event is resolved by a linear scan of the slot memory, one slot read per
// cycle through its single read port. An event whose key sits in slot k ends
// once slot k has been checked; a new key or a dropped event ends once all
// slots in use have been read. busy falls in the cycle done_o is shown. Slots
// are filled in order and never freed, so no clearing pass follows reset.
module persistent_mismatch_streak_table_unit import pmst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // event command
  input  logic                  start,
  output logic                  busy,
  input  logic [FRAME_W-1:0]    frame_number_i,
  input  logic                  layer_id_i,
  input  logic [XY_W-1:0]       map_x_i,
  input  logic [XY_W-1:0]       map_y_i,
  input  logic [ENTRY_W-1:0]    expected_entry_i,
  input  logic [ENTRY_W-1:0]    actual_entry_i,
  // result
  output logic                  done_o,
  output logic                  persistent_report_o,
  output logic [STREAK_W-1:0]   streak_length_o,
  output logic [SLOT_OUT_W-1:0] slot_number_o,
  output logic                  event_dropped_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [STREAK_W-1:0] thr;
  mem_req_t            mem_req;
  slot_entry_t         mem_wdata, mem_rdata;
  logic [SLOT_W-1:0]   ram_rdata;

  // threshold register
  pmst_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  // slot table
  pmst_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.wr_en),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (ram_rdata)
  );

  assign mem_rdata = slot_entry_t'(ram_rdata);

  // scan and update sequencer
  pmst_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .frame_number_i      (frame_number_i),
    .layer_id_i          (layer_id_i),
    .map_x_i             (map_x_i),
    .map_y_i             (map_y_i),
    .expected_entry_i    (expected_entry_i),
    .actual_entry_i      (actual_entry_i),
    .thr_i               (thr),
    .mem_req_o           (mem_req),
    .mem_wdata_o         (mem_wdata),
    .mem_rdata_i         (mem_rdata),
    .done_o              (done_o),
    .persistent_report_o (persistent_report_o),
    .streak_length_o     (streak_length_o),
    .slot_number_o       (slot_number_o),
    .event_dropped_o     (event_dropped_o)
  );

endmodule
